// File: sv/deferred_free_slot_allocator_assert.svh
// Assertion macros for the slot allocator.
`ifndef DEFERRED_FREE_SLOT_ALLOCATOR_ASSERT_SVH
`define DEFERRED_FREE_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define DFSA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DFSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/dfsa_pkg.sv
package dfsa_pkg;

   localparam int SLOTS_DEFAULT = 64;
   localparam int SLOT_W        = 6;
   localparam int STATUS_W      = 2;
   localparam int FREED_W       = 7;
   localparam int MODE_W        = 2;
   localparam int FIF_W         = 4;
   localparam int CDOWN_W       = 5;
   localparam logic [FIF_W-1:0] FIF_RESET = 4'd2;

   localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RETIRE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_LIST_FULL = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [SLOT_W-1:0] slot;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   granted_slot;
      logic [STATUS_W-1:0] status;
      logic [FREED_W-1:0]  freed_count;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_RETIRE = 2'd1,
      OP_TICK   = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [SLOT_W-1:0] slot;
   } cmd_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic [CDOWN_W-1:0] cdown;
   } ret_entry_type;

endpackage

// File: sv/dfsa_ram.sv
module dfsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/dfsa_front.sv
module dfsa_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dfsa_pkg::req_type req,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output dfsa_pkg::cmd_type cmd
);

   dfsa_pkg::cmd_type q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   dfsa_pkg::cmd_type cls;
   logic              push, pop;

   // classify
   always_comb begin
      cls.slot = '0;
      case (req.mode)
         dfsa_pkg::MODE_ALLOC: begin
            cls.op = dfsa_pkg::OP_ALLOC;
         end
         dfsa_pkg::MODE_RETIRE: begin
            cls.op   = dfsa_pkg::OP_RETIRE;
            cls.slot = req.slot;
         end
         dfsa_pkg::MODE_TICK: begin
            cls.op = dfsa_pkg::OP_TICK;
         end
         default: begin
            cls.op = dfsa_pkg::OP_NOP;
         end
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// File: sv/dfsa_back.sv
module dfsa_back #(
   parameter int SLOTS = dfsa_pkg::SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [dfsa_pkg::FIF_W-1:0]     frames_in_flight,
   input  logic                           cmd_valid,
   output logic                           cmd_ready,
   input  dfsa_pkg::cmd_type              cmd,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output dfsa_pkg::rsp_type              rsp
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int RW = $bits(dfsa_pkg::ret_entry_type);
   localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
   localparam logic [CW-1:0] TOP_C   = CW'(SLOTS - 1);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_ALLOC = 3'b010,
      S_TICK  = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   logic [CW-1:0]                 free_count_ff, free_count_in;
   logic [CW-1:0]                 low_ff, low_in;
   logic [CW-1:0]                 ret_count_ff, ret_count_in;
   logic [AW-1:0]                 idx_ff, idx_in;
   logic [CW-1:0]                 freed_ff, freed_in;
   logic                          pop_dflt_ff, pop_dflt_in;
   logic [dfsa_pkg::SLOT_W-1:0]   pop_val_ff, pop_val_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   dfsa_pkg::rsp_type             rsp_ff, rsp_in;

   logic                          fs_we, fs_re;
   logic [AW-1:0]                 fs_waddr, fs_raddr;
   logic [dfsa_pkg::SLOT_W-1:0]   fs_wdata, fs_rdata;
   logic                          rl_we, rl_re;
   logic [AW-1:0]                 rl_waddr, rl_raddr;
   dfsa_pkg::ret_entry_type       rl_wdata, rl_rdata;

   logic [CW-1:0]                 fc_m1, rc_m1, idx_p1;
   logic [dfsa_pkg::CDOWN_W-1:0]  cdown_dec;
   logic                          out_free;

   dfsa_ram #(.WIDTH(dfsa_pkg::SLOT_W), .DEPTH(SLOTS)) u_free_stack (
      .clock (clock),
      .we    (fs_we),
      .waddr (fs_waddr),
      .wdata (fs_wdata),
      .re    (fs_re),
      .raddr (fs_raddr),
      .rdata (fs_rdata)
   );

   dfsa_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_retired (
      .clock (clock),
      .we    (rl_we),
      .waddr (rl_waddr),
      .wdata (rl_wdata),
      .re    (rl_re),
      .raddr (rl_raddr),
      .rdata (rl_rdata)
   );

   assign fc_m1     = free_count_ff - CW'(1);
   assign rc_m1     = ret_count_ff - CW'(1);
   assign idx_p1    = CW'(idx_ff) + CW'(1);
   assign cdown_dec = (rl_rdata.cdown == '0) ? '0 : rl_rdata.cdown - dfsa_pkg::CDOWN_W'(1);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == S_IDLE) && out_free;

   always_comb begin
      state_in      = state_ff;
      free_count_in = free_count_ff;
      low_in        = low_ff;
      ret_count_in  = ret_count_ff;
      idx_in        = idx_ff;
      freed_in      = freed_ff;
      pop_dflt_in   = pop_dflt_ff;
      pop_val_in    = pop_val_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      fs_we         = 1'b0;
      fs_waddr      = '0;
      fs_wdata      = '0;
      fs_re         = 1'b0;
      fs_raddr      = '0;
      rl_we         = 1'b0;
      rl_waddr      = '0;
      rl_wdata      = '0;
      rl_re         = 1'b0;
      rl_raddr      = '0;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               rsp_in = '0;
               case (cmd.op)
                  dfsa_pkg::OP_ALLOC: begin
                     if (free_count_ff == '0) begin
                        rsp_in.status = dfsa_pkg::ST_NO_FREE;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        // entries below the low mark were never written and read as their reset slot number
                        fs_re         = 1'b1;
                        fs_raddr      = fc_m1[AW-1:0];
                        free_count_in = fc_m1;
                        pop_dflt_in   = (fc_m1 < low_ff);
                        pop_val_in    = dfsa_pkg::SLOT_W'(TOP_C - fc_m1);
                        if (fc_m1 < low_ff) begin
                           low_in = fc_m1;
                        end
                        state_in = S_ALLOC;
                     end
                  end
                  dfsa_pkg::OP_RETIRE: begin
                     if (ret_count_ff == SLOTS_C) begin
                        rsp_in.status = dfsa_pkg::ST_LIST_FULL;
                     end else begin
                        rl_we          = 1'b1;
                        rl_waddr       = ret_count_ff[AW-1:0];
                        rl_wdata.slot  = cmd.slot;
                        rl_wdata.cdown = dfsa_pkg::CDOWN_W'(frames_in_flight)
                                         + dfsa_pkg::CDOWN_W'(1);
                        ret_count_in   = ret_count_ff + CW'(1);
                     end
                     rsp_valid_in = 1'b1;
                  end
                  dfsa_pkg::OP_TICK: begin
                     freed_in = '0;
                     idx_in   = '0;
                     if (ret_count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        rl_re    = 1'b1;
                        rl_raddr = '0;
                        state_in = S_TICK;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_ALLOC: begin
            rsp_in              = '0;
            rsp_in.granted_slot = pop_dflt_ff ? pop_val_ff : fs_rdata;
            rsp_valid_in        = 1'b1;
            state_in            = S_IDLE;
         end
         S_TICK: begin
            if (cdown_dec != '0) begin
               rl_we          = 1'b1;
               rl_waddr       = idx_ff;
               rl_wdata.slot  = rl_rdata.slot;
               rl_wdata.cdown = cdown_dec;
               if (idx_p1 < ret_count_ff) begin
                  idx_in   = idx_p1[AW-1:0];
                  rl_re    = 1'b1;
                  rl_raddr = idx_p1[AW-1:0];
               end else begin
                  rsp_in             = '0;
                  rsp_in.freed_count = dfsa_pkg::FREED_W'(freed_ff);
                  rsp_valid_in       = 1'b1;
                  state_in           = S_IDLE;
               end
            end else begin
               if (free_count_ff < SLOTS_C) begin
                  fs_we         = 1'b1;
                  fs_waddr      = free_count_ff[AW-1:0];
                  fs_wdata      = rl_rdata.slot;
                  free_count_in = free_count_ff + CW'(1);
                  freed_in      = freed_ff + CW'(1);
               end
               ret_count_in = rc_m1;
               if (CW'(idx_ff) == rc_m1) begin
                  rsp_in             = '0;
                  rsp_in.freed_count = dfsa_pkg::FREED_W'(freed_in);
                  rsp_valid_in       = 1'b1;
                  state_in           = S_IDLE;
               end else begin
                  // last entry moves into this place; check it next
                  rl_re    = 1'b1;
                  rl_raddr = rc_m1[AW-1:0];
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         free_count_ff <= SLOTS_C;
         low_ff        <= SLOTS_C;
         ret_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_count_ff <= free_count_in;
         low_ff        <= low_in;
         ret_count_ff  <= ret_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      freed_ff    <= freed_in;
      pop_dflt_ff <= pop_dflt_in;
      pop_val_ff  <= pop_val_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: sv/deferred_free_slot_allocator.sv
// Retire, unused mode and allocate with no free slot are answered from idle; allocate adds
// the registered free-stack read, and tick walks the retired list entry by entry.
// Throughput is set by the back end's single sequencer: a retire per cycle while results
// are taken, an allocate holds it for its free-stack read, a tick for its whole list walk.
// Synchronous reset; no clearing pass: a low-water mark on the free stack makes untouched
// entries read as their reset slot number, so requests are taken right after reset.
`include "deferred_free_slot_allocator_assert.svh"

module deferred_free_slot_allocator #(
   parameter int SLOTS = dfsa_pkg::SLOTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  dfsa_pkg::req_type          req,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output dfsa_pkg::rsp_type          rsp,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [dfsa_pkg::FIF_W-1:0] csr_data
);

   logic [dfsa_pkg::FIF_W-1:0] fif_ff, fif_in;
   logic                       cmd_valid, cmd_ready;
   dfsa_pkg::cmd_type          cmd;

   assign csr_ready = 1'b1;
   assign fif_in    = (csr_valid && csr_ready) ? csr_data : fif_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fif_ff <= dfsa_pkg::FIF_RESET;
      end else begin
         fif_ff <= fif_in;
      end
   end

   dfsa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   dfsa_back #(.SLOTS(SLOTS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .frames_in_flight (fif_ff),
      .cmd_valid        (cmd_valid),
      .cmd_ready        (cmd_ready),
      .cmd              (cmd),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp              (rsp)
   );

   `DFSA_ASSERT_NOW(a_no_free_no_grant, clock, reset,
      rsp_valid && (rsp.status == dfsa_pkg::ST_NO_FREE),
      rsp.granted_slot == '0 && rsp.freed_count == '0, "no-free result carries a slot")
   `DFSA_ASSERT_NOW(a_full_clean, clock, reset,
      rsp_valid && (rsp.status == dfsa_pkg::ST_LIST_FULL),
      rsp.granted_slot == '0 && rsp.freed_count == '0, "list-full result carries data")
   `DFSA_ASSERT_NOW(a_freed_ok, clock, reset,
      rsp_valid && (rsp.freed_count != '0),
      rsp.status == dfsa_pkg::ST_OK && rsp.granted_slot == '0, "freed count with bad status")
   `DFSA_ASSERT_NEXT(a_cmd_only_when_out_free, clock, reset, cmd_valid && cmd_ready,
      !rsp_valid || rsp_ready || $past(rsp_valid) == 1'b0 || $past(rsp_ready),
      "command taken while result blocked")

endmodule
